@@ src/vma_pkg.sv @@
// shared types and constants for the validated moving average core
`default_nettype none
package vma_pkg;

  typedef logic signed [15:0] sample_t;
  typedef logic        [7:0]  count_t;

  // register file layout
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_LOWER = 2'd0;
  localparam reg_idx_t REG_UPPER = 2'd1;
  localparam reg_idx_t REG_LIMIT = 2'd2;

  // register reset values
  localparam sample_t LOWER_RST = 16'sh8000;
  localparam sample_t UPPER_RST = 16'sh7FFF;
  localparam count_t  LIMIT_RST = 8'd10;
  localparam count_t  COUNT_MAX = 8'hFF;

endpackage
`default_nettype wire

@@ src/vma_if.sv @@
// stream interfaces for sample and result beats
`default_nettype none
interface vma_in_if;
  import vma_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface vma_out_if;
  import vma_pkg::*;
  logic    valid;
  logic    ready;
  sample_t average;
  logic    accepted;
  count_t  errors;
  logic    inoperative;
  modport source (output valid, output average, output accepted, output errors,
                  output inoperative, input ready);
  modport sink   (input valid, input average, input accepted, input errors,
                  input inoperative, output ready);
endinterface
`default_nettype wire

@@ src/validated_moving_average_core.sv @@
// validated moving average core: range check, ring memory and running mean
//
// One sensor channel. Each beat on in_ch carries a signed 16-bit sample; each
// accepted beat gives exactly one result beat on out_ch with the mean of the
// ring, an accepted flag, the out-of-range count and the inoperative flag.
// The user must write bounds and error limit over the APB port while the core
// idles; the core does not enforce it. A result takes memory read, sum update,
// reciprocal multiply and correction into the output register. Throughput:
// one sample per cycle unless out_ch stalls; the ring has one write and one
// read port, and consecutive samples hit different slots if RING_LENGTH > 1.
// The divide by RING_LENGTH is a reciprocal multiply plus one correction step.
// Reset (rst_n low, synchronous) empties the pipeline, zeroes the sum, count
// and held mean, restores the registers and marks every ring slot as zero
// through per-slot valid bits, so no clearing pass is needed.
// When the receiver stalls, the output register holds its beat and the stages
// behind it fill; in_ch.ready drops only once all stages are occupied.
// After the error limit is reached, samples are still taken but leave the
// state alone and return the held mean with inoperative set.
`default_nettype none
module validated_moving_average_core #(
  parameter int unsigned RING_LENGTH = 8
) (
  input  wire                          clk,
  input  wire                          rst_n,
  vma_in_if.sink                       in_ch,
  vma_out_if.source                    out_ch,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [vma_pkg::ADDR_W-1:0]   paddr,
  input  wire  [vma_pkg::DATA_W-1:0]   pwdata,
  output logic [vma_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import vma_pkg::*;

  localparam int unsigned SLOT_W = (RING_LENGTH > 1) ? $clog2(RING_LENGTH) : 1;
  localparam int unsigned SUM_W  = 16 + SLOT_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING_LENGTH - 1);
  localparam logic [31:0]       RECIP     = 32'((64'd1 << 32) / RING_LENGTH);
  localparam logic [SUM_W-1:0]  LEN_C     = SUM_W'(RING_LENGTH);

  // configuration registers
  sample_t lower_r, upper_r;
  count_t  limit_r;
  logic    cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_r <= LOWER_RST;
      upper_r <= UPPER_RST;
      limit_r <= LIMIT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_LOWER: lower_r <= pwdata[15:0];
        REG_UPPER: upper_r <= pwdata[15:0];
        REG_LIMIT: limit_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_LOWER: prdata = {16'd0, lower_r};
      REG_UPPER: prdata = {16'd0, upper_r};
      REG_LIMIT: prdata = {24'd0, limit_r};
      default:   prdata = '0;
    endcase
  end

  // stage enables, collapsing bubbles from the output backwards
  logic s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic en1, en2, en3, en_o, in_fire;

  assign en_o        = !out_v_r || out_ch.ready;
  assign en3         = !s3_v_r || en_o;
  assign en2         = !s2_v_r || en3;
  assign en1         = !s1_v_r || en2;
  assign in_ch.ready = en1;
  assign in_fire     = in_ch.valid && en1;

  // front end: range check and channel bookkeeping at acceptance
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  count_t            tally_r, tally_nxt;
  logic              dead_r, dead_nxt;
  logic              in_range;

  assign in_range = (in_ch.sample >= lower_r) && (in_ch.sample <= upper_r);

  always_comb begin
    slot_nxt  = slot_r;
    tally_nxt = tally_r;
    dead_nxt  = dead_r;
    if (!dead_r) begin
      slot_nxt = (slot_r == LAST_SLOT) ? '0 : slot_r + 1'b1;
      if (!in_range) begin
        tally_nxt = (tally_r != COUNT_MAX) ? tally_r + 1'b1 : tally_r;
        dead_nxt  = (tally_nxt >= limit_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r  <= '0;
      tally_r <= '0;
      dead_r  <= 1'b0;
    end else if (in_fire) begin
      slot_r  <= slot_nxt;
      tally_r <= tally_nxt;
      dead_r  <= dead_nxt;
    end
  end

  // stage 1 registers
  logic              s1_act_r, s1_took_r, s1_dead_r, s1_oldv_r;
  logic [SLOT_W-1:0] s1_slot_r;
  sample_t           s1_sample_r, s1_old_r;
  count_t            s1_err_r;
  logic              s1_wr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en1) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_act_r    <= !dead_r;
      s1_took_r   <= !dead_r && in_range;
      s1_dead_r   <= dead_nxt;
      s1_err_r    <= tally_nxt;
      s1_slot_r   <= slot_r;
      s1_sample_r <= in_ch.sample;
    end
  end

  // ring memory, read at acceptance and written back from stage 1
  sample_t                 ring_mem [RING_LENGTH];
  logic [RING_LENGTH-1:0]  ring_vld_r;

  assign s1_wr = s1_v_r && en2 && s1_took_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_old_r  <= ring_mem[slot_r];
      s1_oldv_r <= ring_vld_r[slot_r];
    end
    if (s1_wr) begin
      ring_mem[s1_slot_r] <= s1_sample_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_vld_r <= '0;
    end else if (s1_wr) begin
      ring_vld_r[s1_slot_r] <= 1'b1;
    end
  end

  // running sum update
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  sample_t                 old_val;

  assign old_val = s1_oldv_r ? s1_old_r : '0;
  assign sum_nxt = sum_r - SUM_W'(old_val) + SUM_W'(s1_sample_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (s1_wr) begin
      sum_r <= sum_nxt;
    end
  end

  // stage 2 registers
  logic                    s2_act_r, s2_took_r, s2_dead_r;
  count_t                  s2_err_r;
  logic signed [SUM_W-1:0] s2_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en2) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_act_r  <= s1_act_r;
      s2_took_r <= s1_took_r;
      s2_dead_r <= s1_dead_r;
      s2_err_r  <= s1_err_r;
      s2_sum_r  <= s1_took_r ? sum_nxt : sum_r;
    end
  end

  // magnitude and reciprocal multiply
  logic              s2_neg;
  logic [SUM_W-1:0]  s2_mag;
  logic [SUM_W+31:0] s2_prod;

  assign s2_neg  = s2_sum_r[SUM_W-1];
  assign s2_mag  = s2_neg ? SUM_W'(-s2_sum_r) : SUM_W'(s2_sum_r);
  assign s2_prod = (SUM_W+32)'(s2_mag) * (SUM_W+32)'(RECIP);

  // stage 3 registers
  logic             s3_act_r, s3_took_r, s3_dead_r, s3_neg_r;
  count_t           s3_err_r;
  logic [SUM_W-1:0] s3_mag_r, s3_q0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en3) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_act_r  <= s2_act_r;
      s3_took_r <= s2_took_r;
      s3_dead_r <= s2_dead_r;
      s3_err_r  <= s2_err_r;
      s3_neg_r  <= s2_neg;
      s3_mag_r  <= s2_mag;
      s3_q0_r   <= s2_prod[SUM_W+31:32];
    end
  end

  // quotient correction and sign restore
  logic [2*SUM_W-1:0] s3_qn;
  logic [SUM_W-1:0]   s3_rem;
  logic [16:0]        s3_q;
  sample_t            s3_avg, avg_nxt, held_r;

  assign s3_qn  = (2*SUM_W)'(s3_q0_r) * (2*SUM_W)'(LEN_C);
  assign s3_rem = s3_mag_r - s3_qn[SUM_W-1:0];
  assign s3_q   = 17'(s3_q0_r) + ((s3_rem >= LEN_C) ? 17'd1 : 17'd0);
  assign s3_avg = s3_neg_r ? 16'(-s3_q) : s3_q[15:0];
  assign avg_nxt = s3_act_r ? s3_avg : held_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (en_o && s3_v_r && s3_act_r) begin
      held_r <= s3_avg;
    end
  end

  // output register
  sample_t out_avg_r;
  logic    out_acc_r, out_dead_r;
  count_t  out_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en_o) begin
      out_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_o) begin
      out_avg_r  <= avg_nxt;
      out_acc_r  <= s3_took_r;
      out_err_r  <= s3_err_r;
      out_dead_r <= s3_dead_r;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.average     = out_avg_r;
  assign out_ch.accepted    = out_acc_r;
  assign out_ch.errors      = out_err_r;
  assign out_ch.inoperative = out_dead_r;

  // checks
  a_dead_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    dead_r |=> dead_r)
    else $error("inoperative flag cleared without reset");

  a_no_slot_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && s1_wr) |-> (slot_r != s1_slot_r))
    else $error("ring read and write hit the same slot in one cycle");

  a_dead_not_taken: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_dead_r) |-> !out_acc_r)
    else $error("inoperative result marked as accepted");

  a_dead_holds_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && dead_r) |=> $stable(tally_r) && $stable(slot_r) && $stable(sum_r))
    else $error("inoperative channel changed its state");

endmodule
`default_nettype wire
